FILE: hdl/bbc_pkg.sv
// shared constants and types for the 3x3 box blur with border copy
package bbc_pkg;

  // line store depth and address width
  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);

  // field widths
  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;

  // nine 8-bit values need four extra bits
  localparam int SUM_W = PIX_W + 4;

  // divide by nine as multiply by round-up of 2^16 / 9, then shift
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((1 << RECIP_SHIFT) / 9 + 1);

  // image size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // one pixel on its way through the window stage
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   mean;
    logic   border;
    pix_t   pixel;
  } item_t;

  // one pixel with its window sum, handed to the result stage
  typedef struct packed {
    coord_t row;
    coord_t col;
    logic   mean;
    logic   border;
    pix_t   pixel;
    sum_t   sum;
  } sum_item_t;

endpackage

FILE: hdl/bbc_pix_if.sv
// input pixel stream channel
interface bbc_pix_if;
  logic          valid;
  logic          ready;
  bbc_pkg::pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

FILE: hdl/bbc_res_if.sv
// result stream channel
interface bbc_res_if;
  logic            valid;
  logic            ready;
  bbc_pkg::coord_t out_row;
  bbc_pkg::coord_t out_col;
  bbc_pkg::pix_t   out_value;
  logic            last_of_run;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last_of_run, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input last_of_run, output ready);
endinterface

FILE: hdl/bbc_cfg_if.sv
// configuration write channel for the image size register
interface bbc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bbc_pkg::SIZE_W-1:0]  image_size;

  modport source (output valid, output image_size, input ready);
  modport sink (input valid, input image_size, output ready);
endinterface

FILE: hdl/bbc_line_ram.sv
// single line store: one write port, one registered read port, read-first
module bbc_line_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bbc_pkg::ADDR_W-1:0] waddr,
  input  bbc_pkg::pix_t              wdata,
  input  logic                       re,
  input  logic [bbc_pkg::ADDR_W-1:0] raddr,
  output bbc_pkg::pix_t              rdata
);

  bbc_pkg::pix_t mem [bbc_pkg::MAX_SIZE];

  // write and registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bbc_window.sv
// window stage: joins line store data with the pixel, keeps the 3x3 window, sums it
module bbc_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bbc_pkg::item_t             in_item,
  input  bbc_pkg::pix_t              top,
  input  bbc_pkg::pix_t              mid,
  output logic                       upper_we,
  output logic [bbc_pkg::ADDR_W-1:0] upper_waddr,
  output bbc_pkg::pix_t              upper_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bbc_pkg::sum_item_t         out_item
);

  logic           s1_valid;
  bbc_pkg::item_t s1;
  bbc_pkg::pix_t  win [6];
  logic           advance;
  bbc_pkg::sum_t  sum;

  assign advance  = s1_valid && out_ready;
  assign in_ready = !s1_valid || out_ready;

  // stage register, memory read data lines up with it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1 <= in_item;
    end
  end

  // shift the window by one column on every transfer out of the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1.pixel;
    end
  end

  // sum of the nine window pixels
  assign sum = bbc_pkg::SUM_W'(top) + bbc_pkg::SUM_W'(mid) + bbc_pkg::SUM_W'(s1.pixel)
             + bbc_pkg::SUM_W'(win[0]) + bbc_pkg::SUM_W'(win[1]) + bbc_pkg::SUM_W'(win[2])
             + bbc_pkg::SUM_W'(win[3]) + bbc_pkg::SUM_W'(win[4]) + bbc_pkg::SUM_W'(win[5]);

  // middle row data moves up into the upper line store
  assign upper_we    = advance;
  assign upper_waddr = s1.col[bbc_pkg::ADDR_W-1:0];
  assign upper_wdata = mid;

  assign out_valid       = s1_valid;
  assign out_item.row    = s1.row;
  assign out_item.col    = s1.col;
  assign out_item.mean   = s1.mean;
  assign out_item.border = s1.border;
  assign out_item.pixel  = s1.pixel;
  assign out_item.sum    = sum;

endmodule

FILE: hdl/bbc_out_stage.sv
// result stage: divides the window sum by nine and sends mean and border copy
module bbc_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bbc_pkg::sum_item_t in_item,
  bbc_res_if.source          res
);

  logic               s2_valid;
  bbc_pkg::sum_item_t s2;
  logic               mean_pend;
  logic               border_pend;
  logic               both_pend;
  logic               done;
  logic [bbc_pkg::SUM_W+bbc_pkg::RECIP_W-1:0] prod;
  bbc_pkg::pix_t      mean;

  assign both_pend = mean_pend && border_pend;
  assign done      = res.valid && res.ready && !both_pend;
  assign in_ready  = !s2_valid || done;

  // hold the item until its last result transfer; items with no result drop out
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid    <= 1'b0;
      mean_pend   <= 1'b0;
      border_pend <= 1'b0;
    end else if (in_ready) begin
      s2_valid    <= in_valid && (in_item.mean || in_item.border);
      mean_pend   <= in_valid && in_item.mean;
      border_pend <= in_valid && in_item.border;
    end else if (res.valid && res.ready) begin
      mean_pend <= 1'b0;
    end
    if (in_ready && in_valid) begin
      s2 <= in_item;
    end
  end

  // truncated divide by nine through the reciprocal
  assign prod = s2.sum * bbc_pkg::RECIP_9;
  assign mean = prod[bbc_pkg::RECIP_SHIFT +: bbc_pkg::PIX_W];

  // mean of the pixel up and left goes first, then the border copy
  assign res.valid = s2_valid;
  always_comb begin
    if (mean_pend) begin
      res.out_row     = s2.row - 1'b1;
      res.out_col     = s2.col - 1'b1;
      res.out_value   = mean;
      res.last_of_run = !border_pend;
    end else begin
      res.out_row     = s2.row;
      res.out_col     = s2.col;
      res.out_value   = s2.pixel;
      res.last_of_run = 1'b1;
    end
  end

endmodule

FILE: hdl/box_blur_3x3_border_copy_top.sv
// 3x3 box blur with border copy: one pixel per cycle in unless the result port stalls
// a pixel's results are registered in the window stage and then in the result stage
// throughput: one pixel per cycle, set by the line store read in the transfer cycle, when
//   not stalled; a pixel with mean and border copy holds the single result port for both
// reset: counters to row 0 column 0, image size 1024, window cleared;
//   line stores are not cleared, every entry is written before it is used
module box_blur_3x3_border_copy_top (
  input  logic      clk,
  input  logic      rst,
  bbc_pix_if.sink   pix,
  bbc_cfg_if.sink   cfg,
  bbc_res_if.source res
);

  logic                        accept;
  logic [bbc_pkg::SIZE_W-1:0]  eff_size;
  bbc_pkg::coord_t             size_m1;
  bbc_pkg::coord_t             size_m1_next;
  bbc_pkg::coord_t             row;
  bbc_pkg::coord_t             col;
  bbc_pkg::item_t              item;
  bbc_pkg::pix_t               top;
  bbc_pkg::pix_t               mid;
  logic                        upper_we;
  logic [bbc_pkg::ADDR_W-1:0]  upper_waddr;
  bbc_pkg::pix_t               upper_wdata;
  logic                        win_ready;
  logic                        sum_valid;
  logic                        sum_ready;
  bbc_pkg::sum_item_t          sum_item;
  logic [bbc_pkg::SIZE_W-1:0]  size_dec;

  assign cfg.ready = 1'b1;
  assign pix.ready = win_ready;
  assign accept    = pix.valid && pix.ready;

  // clamp the written size to 1..MAX_SIZE and keep size minus one
  always_comb begin
    if (cfg.image_size == '0) begin
      eff_size = bbc_pkg::SIZE_W'(1);
    end else if (cfg.image_size > bbc_pkg::SIZE_W'(bbc_pkg::MAX_SIZE)) begin
      eff_size = bbc_pkg::SIZE_W'(bbc_pkg::MAX_SIZE);
    end else begin
      eff_size = cfg.image_size;
    end
  end
  assign size_dec     = eff_size - bbc_pkg::SIZE_W'(1);
  assign size_m1_next = size_dec[bbc_pkg::COORD_W-1:0];

  // size register and raster counters, a size write restarts the image
  always_ff @(posedge clk) begin
    if (rst) begin
      size_m1 <= bbc_pkg::COORD_W'(bbc_pkg::SIZE_RESET - bbc_pkg::SIZE_W'(1));
      row     <= '0;
      col     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      size_m1 <= size_m1_next;
      row     <= '0;
      col     <= '0;
    end else if (accept) begin
      if (col == size_m1) begin
        col <= '0;
        row <= (row == size_m1) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // classify the arriving pixel
  assign item.row    = row;
  assign item.col    = col;
  assign item.mean   = (row >= bbc_pkg::COORD_W'(2)) && (col >= bbc_pkg::COORD_W'(2));
  assign item.border = (row == '0) || (row == size_m1) || (col == '0) || (col == size_m1);
  assign item.pixel  = pix.pixel;

  // row r-2 store, written back from the window stage
  bbc_line_ram u_upper (
    .clk   (clk),
    .we    (upper_we),
    .waddr (upper_waddr),
    .wdata (upper_wdata),
    .re    (accept),
    .raddr (col[bbc_pkg::ADDR_W-1:0]),
    .rdata (top)
  );

  // row r-1 store, takes the new pixel in the transfer cycle
  bbc_line_ram u_middle (
    .clk   (clk),
    .we    (accept),
    .waddr (col[bbc_pkg::ADDR_W-1:0]),
    .wdata (pix.pixel),
    .re    (accept),
    .raddr (col[bbc_pkg::ADDR_W-1:0]),
    .rdata (mid)
  );

  bbc_window u_window (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pix.valid),
    .in_ready    (win_ready),
    .in_item     (item),
    .top         (top),
    .mid         (mid),
    .upper_we    (upper_we),
    .upper_waddr (upper_waddr),
    .upper_wdata (upper_wdata),
    .out_valid   (sum_valid),
    .out_ready   (sum_ready),
    .out_item    (sum_item)
  );

  bbc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sum_valid),
    .in_ready (sum_ready),
    .in_item  (sum_item),
    .res      (res)
  );

endmodule
